@@ rtl/core/ntpdst_pkg.sv @@
// ntpdst_pkg: shared types, constants and helper functions for the ntp to local time block
// no dependencies

package ntpdst_pkg;

   localparam int unsigned OP_WIDTH = 34;
   localparam int unsigned DAY_BITS = 17;
   localparam int unsigned HOUR_BITS = 5;
   localparam int unsigned STEP_BITS = 5;

   localparam logic [31:0] NTP_OFFSET = 32'd2208988800;
   // two's complement of 3600, subtracting it adds the dst hour
   localparam logic [31:0] DST_NEG_SHIFT = 32'd4294963696;
   localparam logic [31:0] SEC_PER_DAY = 32'd86400;
   localparam logic [31:0] SEC_PER_HOUR = 32'd3600;

   localparam logic [STEP_BITS-1:0] DAY_TOP_BIT = STEP_BITS'(DAY_BITS - 1);
   localparam logic [STEP_BITS-1:0] HOUR_TOP_BIT = STEP_BITS'(HOUR_BITS - 1);

   // epoch year residues
   localparam logic [1:0] EPOCH_MOD4 = 2'd2;
   localparam logic [6:0] EPOCH_MOD100 = 7'd70;
   localparam logic [8:0] EPOCH_MOD400 = 9'd370;
   // (1970 + 1970/4) mod 7
   localparam logic [2:0] EPOCH_Q7 = 3'd5;

   // zero-based month codes
   localparam logic [3:0] MON_FEB = 4'd1;
   localparam logic [3:0] MON_MAR = 4'd2;
   localparam logic [3:0] MON_APR = 4'd3;
   localparam logic [3:0] MON_JUN = 4'd5;
   localparam logic [3:0] MON_SEP = 4'd8;
   localparam logic [3:0] MON_OCT = 4'd9;
   localparam logic [3:0] MON_NOV = 4'd10;
   localparam logic [3:0] MON_DEC = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DAYS,
      ST_HOURS,
      ST_YEARS,
      ST_MONTHS,
      ST_DECIDE,
      ST_ADJUST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] utc_seconds;
      logic [31:0] local_seconds;
      logic dst_active;
   } result_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m) inside
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // residue mod 7 of a value below 14
   function automatic logic [2:0] mod7_small(input logic [3:0] v);
      logic [3:0] r;
      r = (v >= 4'd7) ? (v - 4'd7) : v;
      return r[2:0];
   endfunction

endpackage

@@ rtl/core/ntpdst_sub.sv @@
// ntpdst_sub: shared subtract and compare unit
// depends on ntpdst_pkg

module ntpdst_sub (
   input  logic [ntpdst_pkg::OP_WIDTH-1:0] op_a,
   input  logic [ntpdst_pkg::OP_WIDTH-1:0] op_b,
   output logic [ntpdst_pkg::OP_WIDTH-1:0] diff,
   output logic                            borrow
);
   import ntpdst_pkg::*;

   logic [OP_WIDTH:0] full_diff;

   assign full_diff = {1'b0, op_a} - {1'b0, op_b};
   assign diff = full_diff[OP_WIDTH-1:0];
   assign borrow = full_diff[OP_WIDTH];

endmodule

@@ rtl/core/ntpdst_core.sv @@
// ntpdst_core: sequencer and datapath for the calendar breakdown and dst decision
// depends on ntpdst_pkg and ntpdst_sub

module ntpdst_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              ntp_seconds,
   input  logic                     ack,
   output logic                     idle,
   output logic                     done,
   output ntpdst_pkg::result_type   result
);
   import ntpdst_pkg::*;

   state_type state_ff, state_in;

   logic [31:0]           rem_ff, rem_in;
   logic [31:0]           utc_ff, utc_in;
   logic [31:0]           local_ff, local_in;
   logic [DAY_BITS-1:0]   days_ff, days_in;
   logic [HOUR_BITS-1:0]  hour_ff, hour_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [1:0]            y4_ff, y4_in;
   logic [6:0]            y100_ff, y100_in;
   logic [8:0]            y400_ff, y400_in;
   logic [2:0]            q7_ff, q7_in;
   logic [3:0]            month_ff, month_in;
   logic                  dst_ff, dst_in;

   logic [OP_WIDTH-1:0] op_a, op_b, diff;
   logic                borrow;
   logic                leap;
   logic                dst_calc;
   logic [5:0]          day_num, begin_day, end_day;
   logic [3:0]          q7_sum;

   ntpdst_sub u_sub (
      .op_a   (op_a),
      .op_b   (op_b),
      .diff   (diff),
      .borrow (borrow)
   );

   assign leap = (y4_ff == 2'd0) && ((y100_ff != 7'd0) || (y400_ff == 9'd0));

   // dst window from the calendar fields
   assign day_num = {1'b0, days_ff[4:0]} + 6'd1;
   assign begin_day = 6'd31 - {3'd0, mod7_small({1'b0, q7_ff} + 4'd4)};
   assign end_day = 6'd31 - {3'd0, mod7_small({1'b0, q7_ff} + 4'd1)};

   always_comb begin
      dst_calc = 1'b0;
      if ((month_ff >= MON_APR) && (month_ff <= MON_SEP)) begin
         dst_calc = 1'b1;
      end else if (month_ff == MON_MAR) begin
         dst_calc = (day_num > begin_day) || ((day_num == begin_day) && (hour_ff >= 5'd2));
      end else if (month_ff == MON_OCT) begin
         dst_calc = (day_num < end_day) || ((day_num == end_day) && (hour_ff == 5'd0));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DAYS;
         ST_DAYS:   if (step_ff == '0) state_in = ST_HOURS;
         ST_HOURS:  if (step_ff == '0) state_in = ST_YEARS;
         ST_YEARS:  if (borrow) state_in = ST_MONTHS;
         ST_MONTHS: if ((month_ff == MON_DEC) || borrow) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_ADJUST;
         ST_ADJUST: state_in = ST_DONE;
         ST_DONE:   if (ack) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // shared unit operands and handshake outputs
   always_comb begin
      op_a = {2'b00, rem_ff};
      op_b = '0;
      idle = 1'b0;
      done = 1'b0;
      case (state_ff)
         ST_IDLE:   idle = 1'b1;
         ST_LOAD:   op_b = {2'b00, NTP_OFFSET};
         ST_DAYS:   op_b = {2'b00, SEC_PER_DAY} << step_ff;
         ST_HOURS:  op_b = {2'b00, SEC_PER_HOUR} << step_ff;
         ST_YEARS: begin
            op_a = OP_WIDTH'(days_ff);
            op_b = leap ? OP_WIDTH'(366) : OP_WIDTH'(365);
         end
         ST_MONTHS: begin
            op_a = OP_WIDTH'(days_ff);
            op_b = OP_WIDTH'(month_len(month_ff, leap));
         end
         ST_ADJUST: begin
            op_a = {2'b00, utc_ff};
            op_b = {2'b00, DST_NEG_SHIFT};
         end
         ST_DONE:   done = 1'b1;
         default:   op_b = '0;
      endcase
   end

   assign q7_sum = {1'b0, q7_ff} + ((y4_ff == 2'd3) ? 4'd2 : 4'd1);

   // datapath updates
   always_comb begin
      rem_in = rem_ff;
      utc_in = utc_ff;
      local_in = local_ff;
      days_in = days_ff;
      hour_in = hour_ff;
      step_in = step_ff;
      y4_in = y4_ff;
      y100_in = y100_ff;
      y400_in = y400_ff;
      q7_in = q7_ff;
      month_in = month_ff;
      dst_in = dst_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) rem_in = ntp_seconds;
         end
         ST_LOAD: begin
            rem_in = diff[31:0];
            utc_in = diff[31:0];
            days_in = '0;
            hour_in = '0;
            step_in = DAY_TOP_BIT;
         end
         ST_DAYS: begin
            if (!borrow) begin
               rem_in = diff[31:0];
               days_in[step_ff] = 1'b1;
            end
            step_in = (step_ff == '0) ? HOUR_TOP_BIT : step_ff - 1'b1;
            if (step_ff == '0) begin
               y4_in = EPOCH_MOD4;
               y100_in = EPOCH_MOD100;
               y400_in = EPOCH_MOD400;
               q7_in = EPOCH_Q7;
            end
         end
         ST_HOURS: begin
            if (!borrow) begin
               rem_in = diff[31:0];
               hour_in[step_ff[2:0]] = 1'b1;
            end
            if (step_ff != '0) step_in = step_ff - 1'b1;
         end
         ST_YEARS: begin
            if (borrow) begin
               month_in = '0;
            end else begin
               days_in = diff[DAY_BITS-1:0];
               y4_in = y4_ff + 1'b1;
               y100_in = (y100_ff == 7'd99) ? 7'd0 : y100_ff + 1'b1;
               y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 1'b1;
               q7_in = mod7_small(q7_sum);
            end
         end
         ST_MONTHS: begin
            if ((month_ff != MON_DEC) && !borrow) begin
               days_in = diff[DAY_BITS-1:0];
               month_in = month_ff + 1'b1;
            end
         end
         ST_DECIDE: dst_in = dst_calc;
         ST_ADJUST: local_in = dst_ff ? diff[31:0] : utc_ff;
         default:   dst_in = dst_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      utc_ff <= utc_in;
      local_ff <= local_in;
      days_ff <= days_in;
      hour_ff <= hour_in;
      step_ff <= step_in;
      y4_ff <= y4_in;
      y100_ff <= y100_in;
      y400_ff <= y400_in;
      q7_ff <= q7_in;
      month_ff <= month_in;
      dst_ff <= dst_in;
   end

   assign result.utc_seconds = utc_ff;
   assign result.local_seconds = local_ff;
   assign result.dst_active = dst_ff;

endmodule

@@ rtl/core/ntp_seconds_to_local_dst_time.sv @@
// ntp_seconds_to_local_dst_time: ntp seconds to unix utc and local dst-adjusted seconds
// the sequencer walks the shared subtract unit: ntp offset, days and hours bit by bit, then
// whole years since 1970 and whole months into the year, then the dst decision and adjust;
// one request at a time, a new one is taken only after the last result has been handed over
// reset: synchronous active high, clears the sequencer and the result valid flag
// depends on ntpdst_pkg and ntpdst_core

module ntp_seconds_to_local_dst_time (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_ntp_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_utc_seconds,
   output logic [31:0] rsp_local_seconds,
   output logic        rsp_dst_active
);
   import ntpdst_pkg::*;

   // sequencer handshake
   logic       core_idle;
   logic       core_done;
   logic       core_ack;
   result_type core_result;

   // output register parts the core from the result channel
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   // a request is taken only while the sequencer sits idle
   assign req_stall = !core_idle;

   // hand the finished result over when the output register is free or draining
   assign core_ack = core_done && (!rsp_valid_ff || !rsp_stall);

   ntpdst_core u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid && core_idle),
      .ntp_seconds (req_ntp_seconds),
      .ack         (core_ack),
      .idle        (core_idle),
      .done        (core_done),
      .result      (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (core_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = core_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_utc_seconds = rsp_data_ff.utc_seconds;
   assign rsp_local_seconds = rsp_data_ff.local_seconds;
   assign rsp_dst_active = rsp_data_ff.dst_active;

endmodule

@@ bench/ntp_seconds_to_local_dst_time_test.sv @@
// ntp_seconds_to_local_dst_time_test: self-checking bench for the ntp to local dst time block
// predicts utc, local seconds and the dst flag per request and checks every response in order
// depends on ntpdst_pkg and the ntp_seconds_to_local_dst_time rtl
`timescale 1ns / 1ps

module ntp_seconds_to_local_dst_time_test;

   import ntpdst_pkg::*;

   // quiet-cycle limit: the longest hold-off plus the slowest conversion, several times over
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 600;
   // drain time, longer than the slowest conversion walk
   localparam int DRAIN_CYCLES = 250;
   localparam int RANDOM_PER_PHASE = 230;
   localparam int PRESSURE_ITEMS = 16;

   localparam logic [31:0] DST_SHIFT = 32'd3600;
   localparam int unsigned FIRST_YEAR = 1970;
   // last year whose dst window fits below 2^32 unix seconds
   localparam int unsigned LAST_FULL_YEAR = 2105;
   localparam int unsigned MONTH_JANUARY = 1;
   localparam int unsigned MONTH_FEBRUARY = 2;
   localparam int unsigned MONTH_MARCH = 3;
   localparam int unsigned MONTH_APRIL = 4;
   localparam int unsigned MONTH_JUNE = 6;
   localparam int unsigned MONTH_SEPTEMBER = 9;
   localparam int unsigned MONTH_OCTOBER = 10;
   localparam int unsigned MONTH_NOVEMBER = 11;
   localparam int unsigned MONTH_DECEMBER = 12;
   // offsets in the switch-day formula for spring and fall
   localparam int unsigned SPRING_BIAS = 4;
   localparam int unsigned FALL_BIAS = 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_ntp_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_utc_seconds;
   logic [31:0] rsp_local_seconds;
   logic        rsp_dst_active;

   // predicted responses, oldest first
   result_type expected_times[$];
   int         error_count = 0;

   // idling knobs, percent of cycles
   int idle_pct = 0;
   int stall_pct = 0;

   // a flip asks the receiver for one long hold-off
   logic hold_toggle = 1'b0;

   ntp_seconds_to_local_dst_time dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ntp_seconds  (req_ntp_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_utc_seconds  (rsp_utc_seconds),
      .rsp_local_seconds(rsp_local_seconds),
      .rsp_dst_active   (rsp_dst_active)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // calendar helpers, proleptic gregorian
   // ---------------------------------------------------------------------------------

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // month is one-based here
   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      int unsigned len;
      case (m)
         MONTH_FEBRUARY: len = leap_year(y) ? 29 : 28;
         MONTH_APRIL, MONTH_JUNE, MONTH_SEPTEMBER, MONTH_NOVEMBER: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   // day of march or october on which the clock changes
   function automatic int unsigned switch_day(input int unsigned y, input int unsigned bias);
      return 31 - ((5 * y / 4 + bias) % 7);
   endfunction

   // unix seconds of a utc date; days past the month end simply roll over
   function automatic logic [31:0] unix_seconds(input int unsigned y, input int unsigned mo,
                                                input int unsigned d, input int unsigned h,
                                                input int unsigned mi, input int unsigned s);
      longint unsigned days;
      days = 0;
      for (int unsigned yy = FIRST_YEAR; yy < y; yy++) begin
         days += leap_year(yy) ? 366 : 365;
      end
      for (int unsigned mm = 1; mm < mo; mm++) begin
         days += days_in_month(mm, y);
      end
      days += d - 1;
      return 32'(days * 86400 + h * 3600 + mi * 60 + s);
   endfunction

   // ---------------------------------------------------------------------------------
   // predictor: split unix seconds into year, month, day, hour and apply the dst window
   // ---------------------------------------------------------------------------------

   function automatic result_type predict_local_time(input logic [31:0] ntp);
      result_type  r;
      logic [31:0] utc;
      int unsigned days, year, month, day, hour, year_len, spring, fall;
      bit          dst;
      utc = ntp - NTP_OFFSET;
      days = utc / SEC_PER_DAY;
      hour = (utc % SEC_PER_DAY) / SEC_PER_HOUR;

      // whole years first, then whole months of the final year
      year = FIRST_YEAR;
      year_len = 365;
      while (days >= year_len) begin
         days -= year_len;
         year++;
         year_len = leap_year(year) ? 366 : 365;
      end
      month = 1;
      while (month < MONTH_DECEMBER && days >= days_in_month(month, year)) begin
         days -= days_in_month(month, year);
         month++;
      end
      day = days + 1;

      spring = switch_day(year, SPRING_BIAS);
      fall = switch_day(year, FALL_BIAS);
      dst = (month > MONTH_MARCH && month < MONTH_OCTOBER)
         || (month == MONTH_MARCH && (day > spring || (day == spring && hour >= 2)))
         || (month == MONTH_OCTOBER && (day < fall || (day == fall && hour < 1)));

      r.utc_seconds = utc;
      r.local_seconds = dst ? utc + DST_SHIFT : utc;
      r.dst_active = dst;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // stimulus shaping
   // ---------------------------------------------------------------------------------

   // mostly times close to a dst switch or a month or year edge, the rest raw 32-bit values
   function automatic logic [31:0] random_ntp_seconds();
      int unsigned kind, y, d, mo;
      logic [31:0] utc;
      kind = $urandom_range(0, 9);
      y = $urandom_range(FIRST_YEAR, LAST_FULL_YEAR);
      case (kind)
         0, 1, 2, 3: return $urandom();
         4, 5, 6, 7: begin
            // around the spring or fall switch hour, one day either side
            if ($urandom_range(0, 1)) begin
               mo = MONTH_MARCH;
               d = switch_day(y, SPRING_BIAS);
            end else begin
               mo = MONTH_OCTOBER;
               d = switch_day(y, FALL_BIAS);
            end
            d = d + $urandom_range(0, 2) - 1;
            utc = unix_seconds(y, mo, d, $urandom_range(0, 3), $urandom_range(0, 59),
                               $urandom_range(0, 59));
         end
         8: begin
            // within an hour of the start of april, october, march or november
            case ($urandom_range(0, 3))
               0: mo = MONTH_MARCH;
               1: mo = MONTH_APRIL;
               2: mo = MONTH_OCTOBER;
               default: mo = MONTH_NOVEMBER;
            endcase
            utc = unix_seconds(y, mo, 1, 0, 0, 0) + $urandom_range(0, 7200) - 3600;
         end
         default: begin
            // new year and the end of february, leap or not
            if ($urandom_range(0, 1)) utc = unix_seconds(y, MONTH_JANUARY, 1, 0, 0, 0);
            else utc = unix_seconds(y, MONTH_MARCH, 1, 0, 0, 0);
            utc = utc + $urandom_range(0, 172800) - 86400;
         end
      endcase
      return utc + NTP_OFFSET;
   endfunction

   // ---------------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------------

   // valid stays high between back-to-back requests; it drops only for a gap
   task automatic send_request(input logic [31:0] ntp);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_ntp_seconds <= ntp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_times.push_back(predict_local_time(ntp));
   endtask

   task automatic send_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                            input int unsigned h, input int unsigned mi, input int unsigned s);
      send_request(unix_seconds(y, mo, d, h, mi, s) + NTP_OFFSET);
   endtask

   task automatic set_idling(input int sender, input int receiver);
      idle_pct = sender;
      stall_pct = receiver;
   endtask

   // ---------------------------------------------------------------------------------
   // response side: random stall, plus one long hold-off on request
   // ---------------------------------------------------------------------------------

   logic hold_seen = 1'b0;
   int   hold_left = 0;

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_times.size() == 0) begin
            report_mismatch("unexpected response utc", rsp_utc_seconds, '0);
         end else begin
            want = expected_times.pop_front();
            if (rsp_utc_seconds !== want.utc_seconds)
               report_mismatch("utc_seconds", rsp_utc_seconds, want.utc_seconds);
            if (rsp_local_seconds !== want.local_seconds)
               report_mismatch("local_seconds", rsp_local_seconds, want.local_seconds);
            if (rsp_dst_active !== want.dst_active)
               report_mismatch("dst_active", 32'(rsp_dst_active), 32'(want.dst_active));
         end
      end
   end

   // watchdog: ends the run when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   task automatic test_field_extremes();
      send_request(32'h0000_0000);         // wraps to a late count in 2036
      send_request(32'hFFFF_FFFF);
      send_request(NTP_OFFSET);            // unix epoch
      send_request(NTP_OFFSET - 32'd1);    // largest unix count, february 2106
      send_request(32'h8000_0000);
      send_request(32'h7FFF_FFFF);
   endtask

   task automatic test_switch_hours();
      int unsigned spring, fall;
      spring = switch_day(2024, SPRING_BIAS);
      fall = switch_day(2024, FALL_BIAS);
      // spring: day before, hour one and hour two of the switch day
      send_date(2024, MONTH_MARCH, spring - 1, 23, 59, 59);
      send_date(2024, MONTH_MARCH, spring, 1, 59, 59);
      send_date(2024, MONTH_MARCH, spring, 2, 0, 0);
      // fall: day before, last second of hour zero, first of hour one, next day
      send_date(2024, MONTH_OCTOBER, fall - 1, 12, 0, 0);
      send_date(2024, MONTH_OCTOBER, fall, 0, 59, 59);
      send_date(2024, MONTH_OCTOBER, fall, 1, 0, 0);
      send_date(2024, MONTH_OCTOBER, fall + 1, 0, 0, 0);
   endtask

   task automatic test_month_edges();
      send_date(2023, MONTH_MARCH, 31, 23, 59, 59);
      send_date(2023, MONTH_APRIL, 1, 0, 0, 0);
      send_date(2023, MONTH_SEPTEMBER, 30, 23, 59, 59);
      send_date(2023, MONTH_NOVEMBER, 1, 0, 0, 0);
      send_date(2023, MONTH_DECEMBER, 31, 23, 59, 59);
   endtask

   // leap days, and the century years around the end of the rule
   task automatic test_leap_and_century();
      send_date(2000, MONTH_FEBRUARY, 29, 12, 0, 0);
      send_date(2024, MONTH_FEBRUARY, 29, 23, 59, 59);
      send_date(2100, MONTH_FEBRUARY, 28, 23, 59, 59);
      send_date(2100, MONTH_MARCH, 1, 0, 0, 0);
      send_date(2099, MONTH_MARCH, switch_day(2099, SPRING_BIAS), 2, 0, 0);
      send_date(2100, MONTH_MARCH, switch_day(2100, SPRING_BIAS), 2, 0, 0);
      send_date(2105, MONTH_OCTOBER, switch_day(2105, FALL_BIAS), 0, 30, 0);
   endtask

   task automatic test_random_phase(input int sender, input int receiver);
      set_idling(sender, receiver);
      repeat (RANDOM_PER_PHASE) send_request(random_ntp_seconds());
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_toggle = ~hold_toggle;
      repeat (PRESSURE_ITEMS) send_request(random_ntp_seconds());
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (expected_times.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_field_extremes();
      test_switch_hours();
      test_month_edges();
      test_leap_and_century();

      // idling phases: none, sender only, a long receiver hold-off, receiver only, both
      test_random_phase(0, 0);
      test_random_phase(56, 0);
      test_backpressure();
      test_random_phase(0, 56);
      test_random_phase(25, 25);

      finish_run();
   end

endmodule

@@ ntp_seconds_to_local_dst_time.f @@
rtl/core/ntpdst_pkg.sv
rtl/core/ntpdst_sub.sv
rtl/core/ntpdst_core.sv
rtl/core/ntp_seconds_to_local_dst_time.sv
bench/ntp_seconds_to_local_dst_time_test.sv
